FILE: src/tbrc_pkg.sv
`timescale 1ns / 1ps
package tbrc_pkg;

   // Table and ramp geometry
   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int SLOT_MAX_W        = 6;
   localparam int RAMP_LEVELS       = 256;
   localparam int LEVEL_W           = $clog2(RAMP_LEVELS);
   localparam int QUEUE_DEPTH_DEF   = 4;

   // Field widths
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int PIXEL_W   = 16;
   localparam int SLOT_IO_W = 3;
   localparam int BUILT_W   = 4;
   localparam int REFUSED_W = 32;
   localparam int ACC_W     = 16;

   // Command codes
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BUILT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_MODE  = 2'd3;

   localparam logic [BUILT_W-1:0]   BUILT_MAX   = '1;
   localparam logic [REFUSED_W-1:0] REFUSED_MAX = '1;

   // What the front decided for one transaction
   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_HIT   = 3'd1,
      OP_BUILD = 3'd2,
      OP_FULL  = 3'd3,
      OP_MODE  = 3'd4
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [SLOT_MAX_W-1:0]  slot_idx;
      logic [SLOT_IO_W-1:0]   slot_out;
      logic                   in_range;
      logic [COLOR_W-1:0]     fg_color;
      logic [COLOR_W-1:0]     bg_color;
      logic [LEVEL_W-1:0]     coverage;
   } q_item_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [SLOT_IO_W-1:0]   slot_out;
      logic [PIXEL_W-1:0]     pixel;
      logic [BUILT_W-1:0]     tables_built;
      logic [REFUSED_W-1:0]   refused_count;
   } rsp_item_type;

   // Truncating divide by 255, exact for any dividend below 65280 (quotient fits in 8 bits)
   function automatic logic [CHAN_W-1:0] div255(input logic [ACC_W-1:0] x);
      logic [ACC_W:0] t;
      t = (ACC_W+1)'(x) + (ACC_W+1)'(1) + (ACC_W+1)'(x >> 8);
      return t[ACC_W-1:8];
   endfunction

   // Pack three 8-bit channels to RGB565 by truncation
   function automatic logic [PIXEL_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

FILE: src/tbrc_if.sv
`timescale 1ns / 1ps
interface tbrc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [23:0] fg_color;
   logic [23:0] bg_color;
   logic [2:0]  slot_in;
   logic [7:0]  coverage;

   modport source (output valid, command, fg_color, bg_color, slot_in, coverage,
                   input ready);
   modport sink   (input valid, command, fg_color, bg_color, slot_in, coverage,
                   output ready);
endinterface

interface tbrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  slot_out;
   logic [15:0] pixel;
   logic [3:0]  tables_built;
   logic [31:0] refused_count;

   modport source (output valid, status, slot_out, pixel, tables_built, refused_count,
                   input ready);
   modport sink   (input valid, status, slot_out, pixel, tables_built, refused_count,
                   output ready);
endinterface

FILE: src/tbrc_front.sv
`timescale 1ns / 1ps
module tbrc_front #(
   parameter int TABLE_ENTRIES = tbrc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   tbrc_req_if.sink             req,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 q_full,
   output logic                 q_push,
   output tbrc_pkg::q_item_type q_item
);
   import tbrc_pkg::*;

   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [COLOR_W-1:0]       fg_ff [TABLE_ENTRIES];
   logic [COLOR_W-1:0]       bg_ff [TABLE_ENTRIES];
   logic                     mode_ff;

   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [SLOT_W-1:0]        hit_idx;
   logic [SLOT_W-1:0]        free_idx;
   logic                     have_free;
   logic                     in_range;
   q_item_type               item;

   // Compare the pair against every entry and find the lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (fg_ff[i] == req.fg_color) && (bg_ff[i] == req.bg_color);
         if (hit_vec[i]) begin
            hit_idx = hit_idx | SLOT_W'(i);
         end
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      have_free = !(&valid_ff);
      in_range  = 32'(req.slot_in) < TABLE_ENTRIES;
   end

   // Classify the transaction
   always_comb begin
      item          = '0;
      item.fg_color = req.fg_color;
      item.bg_color = req.bg_color;
      item.coverage = req.coverage;
      item.in_range = in_range;
      if (req.command == CMD_READ) begin
         item.kind     = OP_READ;
         item.slot_out = req.slot_in;
         item.slot_idx = in_range ? SLOT_MAX_W'(SLOT_W'(req.slot_in)) : '0;
      end else if (!mode_ff) begin
         item.kind = OP_MODE;
      end else if (|hit_vec) begin
         item.kind     = OP_HIT;
         item.slot_idx = SLOT_MAX_W'(hit_idx);
         item.slot_out = SLOT_IO_W'(hit_idx);
      end else if (have_free) begin
         item.kind     = OP_BUILD;
         item.slot_idx = SLOT_MAX_W'(free_idx);
         item.slot_out = SLOT_IO_W'(free_idx);
      end else begin
         item.kind = OP_FULL;
      end
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign q_item    = item;

   // Hold the mode register and claim slots on a miss
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mode_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (q_push && item.kind == OP_BUILD) begin
            valid_ff[free_idx] <= 1'b1;
         end
      end
   end

   // Store the claimed pair
   always_ff @(posedge clock) begin
      if (q_push && item.kind == OP_BUILD) begin
         fg_ff[free_idx] <= req.fg_color;
         bg_ff[free_idx] <= req.bg_color;
      end
   end

endmodule

FILE: src/tbrc_queue.sv
`timescale 1ns / 1ps
module tbrc_queue #(
   parameter int QUEUE_DEPTH = tbrc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tbrc_pkg::q_item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output tbrc_pkg::q_item_type pop_item
);
   import tbrc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push lost in queue");
`endif

endmodule

FILE: src/tbrc_back.sv
`timescale 1ns / 1ps
module tbrc_back #(
   parameter int TABLE_ENTRIES = tbrc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  tbrc_pkg::q_item_type q_item,
   output logic                 q_pop,
   tbrc_rsp_if.source           rsp
);
   import tbrc_pkg::*;

   localparam int SLOT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int MEM_DEPTH = TABLE_ENTRIES * RAMP_LEVELS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(RAMP_LEVELS - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BUILD = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type            state_ff;
   state_type            state_in;

   // Ramp builder
   logic [SLOT_W-1:0]    bld_slot_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [ACC_W-1:0]     acc_ff   [3];
   logic [CHAN_W:0]      delta_ff [3];

   // Ramp memory
   logic [PIXEL_W-1:0]   ramp_mem [MEM_DEPTH];
   logic [PIXEL_W-1:0]   rd_data_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [PIXEL_W-1:0]   wr_data;

   // Result stages
   logic                 p1_valid_ff;
   rsp_item_type         p1_ff;
   logic                 p1_pix_ff;
   logic                 out_valid_ff;
   rsp_item_type         out_ff;
   rsp_item_type         out_in;
   logic                 p1_move;
   logic                 p1_free;
   logic                 pop_direct;
   logic                 done_load;
   rsp_item_type         p1_in;

   // Counters
   logic [BUILT_W-1:0]   built_ff;
   logic [BUILT_W-1:0]   built_in;
   logic [REFUSED_W-1:0] refused_ff;
   logic [REFUSED_W-1:0] refused_in;

   assign p1_move    = p1_valid_ff && (!out_valid_ff || rsp.ready);
   assign p1_free    = !p1_valid_ff || p1_move;
   assign q_pop      = q_valid && (state_ff == ST_IDLE) && p1_free;
   assign pop_direct = q_pop && (q_item.kind != OP_BUILD);
   assign done_load  = (state_ff == ST_DONE) && p1_free;

   // Sequence builds
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_item.kind == OP_BUILD) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (level_ff == LEVEL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (p1_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Update counters as results enter the first stage
   always_comb begin
      built_in   = built_ff;
      refused_in = refused_ff;
      if (done_load && built_ff != BUILT_MAX) begin
         built_in = built_ff + BUILT_W'(1);
      end
      if (pop_direct && q_item.kind == OP_FULL && refused_ff != REFUSED_MAX) begin
         refused_in = refused_ff + REFUSED_W'(1);
      end
   end

   // Form the first-stage result
   always_comb begin
      p1_in               = '0;
      p1_in.tables_built  = built_in;
      p1_in.refused_count = refused_in;
      if (done_load) begin
         p1_in.status   = STATUS_BUILT;
         p1_in.slot_out = SLOT_IO_W'(bld_slot_ff);
      end else begin
         p1_in.slot_out = q_item.slot_out;
         case (q_item.kind)
            OP_FULL: p1_in.status = STATUS_FULL;
            OP_MODE: p1_in.status = STATUS_MODE;
            default: p1_in.status = STATUS_OK;
         endcase
      end
   end

   // Merge the ramp read into the result
   always_comb begin
      out_in       = p1_ff;
      out_in.pixel = p1_pix_ff ? rd_data_ff : '0;
   end

   // Memory ports: one ramp read per in-range read transaction, one write per build level
   assign rd_en   = pop_direct && q_item.kind == OP_READ && q_item.in_range;
   assign rd_addr = ADDR_W'({SLOT_W'(q_item.slot_idx), q_item.coverage});
   assign wr_en   = state_ff == ST_BUILD;
   assign wr_addr = ADDR_W'({bld_slot_ff, level_ff});
   assign wr_data = pack565(div255(acc_ff[0]), div255(acc_ff[1]), div255(acc_ff[2]));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ramp_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ramp_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         built_ff     <= '0;
         refused_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         built_ff   <= built_in;
         refused_ff <= refused_in;
         if (pop_direct || done_load) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_move) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and the build datapath
   always_ff @(posedge clock) begin
      if (pop_direct || done_load) begin
         p1_ff     <= p1_in;
         p1_pix_ff <= rd_en;
      end
      if (p1_move) begin
         out_ff <= out_in;
      end
      if (q_pop && q_item.kind == OP_BUILD) begin
         bld_slot_ff <= SLOT_W'(q_item.slot_idx);
         level_ff    <= '0;
         for (int c = 0; c < 3; c++) begin
            // Start at 255*bg and step by fg-bg per level
            acc_ff[c]   <= {q_item.bg_color[16-8*c +: 8], 8'h00}
                           - ACC_W'(q_item.bg_color[16-8*c +: 8]);
            delta_ff[c] <= (CHAN_W+1)'(q_item.fg_color[16-8*c +: 8])
                           - (CHAN_W+1)'(q_item.bg_color[16-8*c +: 8]);
         end
      end else if (state_ff == ST_BUILD) begin
         level_ff <= level_ff + LEVEL_W'(1);
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + {{(ACC_W-CHAN_W-1){delta_ff[c][CHAN_W]}}, delta_ff[c]};
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.status        = out_ff.status;
   assign rsp.slot_out      = out_ff.slot_out;
   assign rsp.pixel         = out_ff.pixel;
   assign rsp.tables_built  = out_ff.tables_built;
   assign rsp.refused_count = out_ff.refused_count;

`ifndef SYNTH
   a_build_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUILD && level_ff == LEVEL_LAST |=> state_ff == ST_DONE)
      else $error("ramp build did not finish after last level");

   a_p1_held: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && out_valid_ff && !rsp.ready |=> p1_valid_ff && $stable(p1_ff))
      else $error("first stage overwritten while output stalled");

   a_built_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> built_ff >= $past(built_ff))
      else $error("build counter went backward");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("ramp read during build");
`endif

endmodule

FILE: src/text_blend_ramp_cache_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         valid/ready        command, fg_color, bg_color, slot_in, coverage
// rsp       out        valid/ready        status, slot_out, pixel, tables_built, refused_count
// csr       in         csr_wr_en          csr_wr_data (render mode is RGB565)
//
// Reads, hits and refusals complete one per cycle while rsp is ready and no build is running;
// each passes through the queue, the first result stage and the output register to rsp. A miss
// that builds a ramp holds the back end while it pops the request, makes 256 level writes
// through the ramp memory's single write port and hands off the result. Transactions behind it
// wait in a 4-deep queue. Reset is synchronous; it clears slot valid bits, counters and the
// queue, and sets the mode register to RGB565. Ramp contents are not cleared. rsp stalls hold the result.
module text_blend_ramp_cache_unit #(
   parameter int TABLE_ENTRIES = tbrc_pkg::TABLE_ENTRIES_DEF,
   parameter int QUEUE_DEPTH   = tbrc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tbrc_req_if.sink    req,
   tbrc_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import tbrc_pkg::*;

   logic       q_full;
   logic       q_push;
   q_item_type q_push_item;
   logic       q_pop;
   logic       q_valid;
   q_item_type q_pop_item;

   tbrc_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   tbrc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item)
   );

   tbrc_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_pop_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

FILE: tb/sv/tb_text_blend_ramp_cache_unit.sv
`timescale 1ns / 1ps
module tb_text_blend_ramp_cache_unit;
   import tbrc_pkg::*;

   localparam int          CHAN_FULL  = 255;
   localparam int          SHOW_LIMIT = 20;
   localparam logic [23:0] RGB_BLACK  = 24'h000000;
   localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   tbrc_req_if req_ch ();
   tbrc_rsp_if rsp_ch ();

   text_blend_ramp_cache_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the colour-pair cache
   bit                   mode_rgb565 = 1'b1;
   bit                   pair_valid [TABLE_ENTRIES_DEF];
   logic [COLOR_W-1:0]   pair_fg [TABLE_ENTRIES_DEF];
   logic [COLOR_W-1:0]   pair_bg [TABLE_ENTRIES_DEF];
   logic [BUILT_W-1:0]   ramps_built  = '0;
   logic [REFUSED_W-1:0] full_refusals = '0;

   rsp_item_type pending_rsp [$];
   int unsigned  error_count = 0;
   int unsigned  rsp_seen    = 0;
   bit           no_idle     = 1'b0;

   // Drive the clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Blend one coverage level per channel, then pack to RGB565
   function automatic logic [PIXEL_W-1:0] ramp_pixel(input logic [COLOR_W-1:0] fg,
                                                     input logic [COLOR_W-1:0] bg,
                                                     input logic [7:0] level);
      int unsigned f;
      int unsigned b;
      int unsigned mix;
      logic [7:0]  chan [3];
      for (int k = 0; k < 3; k++) begin
         f = (fg >> (8 * k)) & 8'hFF;
         b = (bg >> (8 * k)) & 8'hFF;
         mix = (f * level + b * (CHAN_FULL - level)) / CHAN_FULL;
         chan[k] = 8'(mix);
      end
      return {chan[2][7:3], chan[1][7:2], chan[0][7:3]};
   endfunction

   // Advance the shadow cache by one transaction and return the response it owes
   function automatic rsp_item_type cache_step(input logic cmd,
                                               input logic [COLOR_W-1:0] fg,
                                               input logic [COLOR_W-1:0] bg,
                                               input logic [2:0] slot,
                                               input logic [7:0] level);
      rsp_item_type r;
      int           free_idx;
      bit           hit;
      r = '0;
      free_idx = -1;
      hit = 1'b0;
      if (cmd == CMD_READ) begin
         r.status = STATUS_OK;
         r.slot_out = slot;
         if (pair_valid[slot])
            r.pixel = ramp_pixel(pair_fg[slot], pair_bg[slot], level);
      end else if (!mode_rgb565) begin
         r.status = STATUS_MODE;
      end else begin
         // Look up the pair; remember the lowest free slot on the way
         for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            if (hit) begin
            end else if (!pair_valid[i]) begin
               if (free_idx < 0) free_idx = i;
            end else if (pair_fg[i] == fg && pair_bg[i] == bg) begin
               hit = 1'b1;
               r.slot_out = 3'(i);
            end
         end
         if (hit) begin
            r.status = STATUS_OK;
         end else if (free_idx >= 0) begin
            pair_fg[free_idx] = fg;
            pair_bg[free_idx] = bg;
            pair_valid[free_idx] = 1'b1;
            if (ramps_built != BUILT_MAX) ramps_built++;
            r.status = STATUS_BUILT;
            r.slot_out = 3'(free_idx);
         end else begin
            if (full_refusals != REFUSED_MAX) full_refusals++;
            r.status = STATUS_FULL;
         end
      end
      r.tables_built = ramps_built;
      r.refused_count = full_refusals;
      return r;
   endfunction

   // Pick an idle stretch: mostly none or short, now and then long
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < SHOW_LIMIT)
         $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_seen, what);
      error_count++;
   endtask

   // Send one transaction; return at the edge that accepts it
   task automatic send_item(input logic cmd, input logic [COLOR_W-1:0] fg,
                            input logic [COLOR_W-1:0] bg, input logic [2:0] slot,
                            input logic [7:0] level);
      int unsigned gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.command  = cmd;
      req_ch.fg_color = fg;
      req_ch.bg_color = bg;
      req_ch.slot_in  = slot;
      req_ch.coverage = level;
      req_ch.valid    = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(cache_step(cmd, fg, bg, slot, level));
   endtask

   // Drop valid and hold until every outstanding response has come back
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Write the render mode; only called with nothing outstanding
   task automatic write_render_mode(input bit rgb565);
      csr_wr_en   = 1'b1;
      csr_wr_data = rgb565;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      mode_rgb565 = rgb565;
   endtask

   // Drive the response ready with random stalls
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = idle_cycles();
         end
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
            if (rsp_ch.slot_out !== want.slot_out)
               report_mismatch($sformatf("slot_out %0d, want %0d",
                                         rsp_ch.slot_out, want.slot_out));
            if (rsp_ch.pixel !== want.pixel)
               report_mismatch($sformatf("pixel %h, want %h", rsp_ch.pixel, want.pixel));
            if (rsp_ch.tables_built !== want.tables_built)
               report_mismatch($sformatf("tables_built %0d, want %0d",
                                         rsp_ch.tables_built, want.tables_built));
            if (rsp_ch.refused_count !== want.refused_count)
               report_mismatch($sformatf("refused_count %0d, want %0d",
                                         rsp_ch.refused_count, want.refused_count));
         end
         rsp_seen++;
      end
   end

   // Build the four extreme pairs back to back, then read near both ends of the first ramp
   task automatic test_build_and_read();
      no_idle = 1'b1;
      send_item(CMD_ACQUIRE, RGB_BLACK, RGB_WHITE, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, RGB_WHITE, RGB_BLACK, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, RGB_WHITE, RGB_WHITE, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, RGB_BLACK, RGB_BLACK, 3'd0, 8'd0);
      no_idle = 1'b0;
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd0, 8'd0);
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd0, 8'd1);
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd0, 8'd254);
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd0, 8'd255);
      // Hit on an existing pair; slot and coverage must be ignored
      send_item(CMD_ACQUIRE, RGB_BLACK, RGB_WHITE, 3'd7, 8'd255);
      // Read with colour fields at all ones; they must be ignored
      send_item(CMD_READ, RGB_WHITE, RGB_WHITE, 3'd1, 8'd128);
      send_item(CMD_READ, RGB_WHITE, RGB_WHITE, 3'd2, 8'd0);
      send_item(CMD_READ, RGB_WHITE, RGB_WHITE, 3'd3, 8'd255);
   endtask

   // With the mode off, acquires are refused uncounted while reads still work
   task automatic test_mode_refusal();
      drain_results();
      write_render_mode(1'b0);
      send_item(CMD_ACQUIRE, RGB_BLACK, RGB_WHITE, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h111111, 24'h222222, 3'd0, 8'd0);
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd0, 8'd77);
      drain_results();
      write_render_mode(1'b1);
   endtask

   // Fill the remaining slots, then miss on a full table
   task automatic test_table_full();
      send_item(CMD_ACQUIRE, 24'h800000, 24'h7FFFFF, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h00FF00, 24'hFF00FF, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h0000FF, 24'hFFFF00, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h5A5A5A, 24'hA5A5A5, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h111111, 24'h222222, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, RGB_WHITE, 24'hFFFFFE, 3'd0, 8'd0);
      send_item(CMD_ACQUIRE, 24'h5A5A5A, 24'hA5A5A5, 3'd0, 8'd0);
      send_item(CMD_READ, RGB_BLACK, RGB_BLACK, 3'd7, 8'd200);
   endtask

   // Random mix of reads, hits and fresh pairs under one render mode
   task automatic test_random_traffic(input int unsigned count, input bit rgb565,
                                      input bit steady, input bit pause_mid);
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      int unsigned        k;
      drain_results();
      write_render_mode(rgb565);
      no_idle = steady;
      for (int unsigned n = 0; n < count; n++) begin
         if (pause_mid && n == count / 2) drain_results();
         fg = COLOR_W'($urandom);
         bg = COLOR_W'($urandom);
         if ($urandom_range(0, 1) == 1) begin
            send_item(CMD_READ, fg, bg, 3'($urandom_range(0, 7)), 8'($urandom));
         end else begin
            // Mostly reuse a cached pair so that hits dominate
            if ($urandom_range(0, 4) != 0) begin
               k = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
               fg = pair_fg[k];
               bg = pair_bg[k];
            end
            send_item(CMD_ACQUIRE, fg, bg, 3'($urandom_range(0, 7)), 8'($urandom));
         end
      end
      drain_results();
      no_idle = 1'b0;
   endtask

   // Reset, run the tests, then settle and decide
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.command  = CMD_ACQUIRE;
      req_ch.fg_color = '0;
      req_ch.bg_color = '0;
      req_ch.slot_in  = '0;
      req_ch.coverage = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_build_and_read();
      test_mode_refusal();
      test_table_full();
      test_random_traffic(130, 1'b1, 1'b0, 1'b1);
      test_random_traffic(120, 1'b0, 1'b0, 1'b0);
      test_random_traffic(120, 1'b1, 1'b1, 1'b0);
      test_random_traffic(130, 1'b1, 1'b0, 1'b1);

      repeat (16) @(posedge clock);
      if (pending_rsp.size() != 0) report_mismatch("responses still outstanding at end");
      if (error_count == 0) begin
         $display("text_blend_ramp_cache_unit regression: pass");
      end else begin
         $display("text_blend_ramp_cache_unit regression: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(5_000_000);
      $display("text_blend_ramp_cache_unit regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
src/tbrc_pkg.sv
src/tbrc_if.sv
src/tbrc_front.sv
src/tbrc_queue.sv
src/tbrc_back.sv
src/text_blend_ramp_cache_unit.sv
tb/sv/tb_text_blend_ramp_cache_unit.sv
